/* src/mtrp_pkg.sv */
// ----------------------------------------------------------------------------
// mtrp_pkg
// Types and constants of the Modbus TCP request parser: parser states,
// status codes, function kinds, register indexes and stream widths.
// ----------------------------------------------------------------------------
package mtrp_pkg;

  // Parser position within the request, one-hot
  typedef enum logic [14:0] {
    S_TID0  = 15'b000000000000001,
    S_TID1  = 15'b000000000000010,
    S_PID0  = 15'b000000000000100,
    S_PID1  = 15'b000000000001000,
    S_LEN0  = 15'b000000000010000,
    S_LEN1  = 15'b000000000100000,
    S_UID   = 15'b000000001000000,
    S_FUNC  = 15'b000000010000000,
    S_ADDR0 = 15'b000000100000000,
    S_ADDR1 = 15'b000001000000000,
    S_NUM0  = 15'b000010000000000,
    S_NUM1  = 15'b000100000000000,
    S_DLEN  = 15'b001000000000000,
    S_DATA  = 15'b010000000000000,
    S_SKIP  = 15'b100000000000000
  } parse_state_t;

  // Output sequencer, one-hot
  typedef enum logic [2:0] {
    C_PARSE = 3'b001,
    C_SUM   = 3'b010,
    C_DATA  = 3'b100
  } ctl_state_t;

  typedef enum logic [1:0] {
    K_READ   = 2'd0,
    K_SINGLE = 2'd1,
    K_MULTI  = 2'd2
  } func_kind_t;

  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_OK   = 3'd1;
  localparam logic [2:0] ST_PID  = 3'd2;
  localparam logic [2:0] ST_FUNC = 3'd3;
  localparam logic [2:0] ST_LEN  = 3'd4;

  localparam int CfgAddrW = 2;
  localparam logic [CfgAddrW-1:0] CFG_READ_FC    = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_WMULTI_FC  = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_WSINGLE_FC = 2'd2;

  localparam int InDataW  = 8;
  localparam int OutFieldW = 115;
  localparam int OutDataW = 120;
  localparam int OutPadW  = OutDataW - OutFieldW;

endpackage

/* src/modbus_tcp_request_parser.sv */
// ----------------------------------------------------------------------------
// modbus_tcp_request_parser
// Parses MBAP header and request PDU from a byte stream, buffers the
// write-multiple payload and reports one summary per chunk, plus the payload when it is complete.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while parsing.
// Output: after the chunk-end transfer the summary passes through the C_SUM
//   state into the output register, then one payload item per cycle while the
//   receiver accepts, paced by the payload RAM's registered read.
// Input is held off from the chunk end until the last item of that chunk is
//   loaded into the output register.
// Reset: control, status and header fields cleared; the payload RAM is not.
module modbus_tcp_request_parser #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mtrp_pkg::CfgAddrW-1:0]     cfg_addr,
  input  logic [7:0]                        cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [7:0] rx_byte
  input  logic [mtrp_pkg::InDataW-1:0]      s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] status, [18:3] transaction_id, [34:19] protocol_id,
  // [50:35] frame_length, [58:51] unit_id, [66:59] function_code,
  // [82:67] register_address, [98:83] register_count, [106:99] byte_count,
  // [114:107] payload_byte, [119:115] zero
  output logic [mtrp_pkg::OutDataW-1:0]     m_tdata,
  // [0] is_payload
  output logic                              m_tuser,
  output logic                              m_tlast
);
  import mtrp_pkg::*;

  localparam int AW = $clog2(MAX_PAYLOAD);
  localparam logic [7:0] MaxPl = 8'(MAX_PAYLOAD);

  logic [7:0] read_fc, wmulti_fc, wsingle_fc;

  parse_state_t parse_state, parse_state_next;
  ctl_state_t   ctl;
  func_kind_t   func_kind;
  logic [2:0]   pend_status, pend_status_next;
  logic [7:0]   payload_seen, payload_seen_next;
  logic [15:0]  tid_reg, pid_reg, len_reg, addr_reg, count_reg;
  logic [7:0]   uid_reg, func_reg, bytecount_reg;

  logic [2:0]   emit_status;
  logic         emit_pl;
  logic [AW-1:0] rd_idx;

  logic [7:0]   mem [MAX_PAYLOAD];
  logic [7:0]   mem_q;
  logic         mem_we, rd_en;
  logic [AW-1:0] rd_addr;

  logic [2:0]   out_status;
  logic [15:0]  out_tid, out_pid, out_len, out_addr, out_count;
  logic [7:0]   out_uid, out_func, out_bc, out_pb;
  logic         out_user, out_last;

  logic         in_acc, out_free, fin_ok, fin_decide, rd_last;
  logic [7:0]   rx;
  logic [2:0]   fin_status;

  assign rx       = s_tdata;
  assign s_tready = (ctl == C_PARSE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign rd_last  = ({{(8-AW){1'b0}}, rd_idx} == bytecount_reg - 8'd1);

  // Next parser state, status and payload tally for the incoming byte
  always_comb begin
    parse_state_next  = parse_state;
    pend_status_next  = pend_status;
    payload_seen_next = payload_seen;
    mem_we            = 1'b0;
    unique case (parse_state)
      S_TID0:  parse_state_next = S_TID1;
      S_TID1:  parse_state_next = S_PID0;
      S_PID0:  parse_state_next = S_PID1;
      S_PID1: begin
        if ({pid_reg[15:8], rx} != 16'd0) begin
          pend_status_next = ST_PID;
          parse_state_next = S_TID0;
        end else begin
          parse_state_next = S_LEN0;
        end
      end
      S_LEN0:  parse_state_next = S_LEN1;
      S_LEN1:  parse_state_next = S_UID;
      S_UID:   parse_state_next = S_FUNC;
      S_FUNC: begin
        if (rx == read_fc || rx == wsingle_fc || rx == wmulti_fc) begin
          parse_state_next = S_ADDR0;
        end else begin
          pend_status_next = ST_FUNC;
          parse_state_next = S_TID0;
        end
      end
      S_ADDR0: parse_state_next = S_ADDR1;
      S_ADDR1: parse_state_next = S_NUM0;
      S_NUM0:  parse_state_next = S_NUM1;
      S_NUM1: begin
        if (func_kind == K_MULTI) begin
          parse_state_next = S_DLEN;
        end else begin
          pend_status_next = ST_OK;
          parse_state_next = S_TID0;
        end
      end
      S_DLEN: begin
        payload_seen_next = 8'd0;
        parse_state_next  = (rx == 8'd0) ? S_TID0 : S_DATA;
      end
      S_DATA: begin
        if (payload_seen == 8'd0 && bytecount_reg >= MaxPl) begin
          pend_status_next = ST_LEN;
          parse_state_next = S_SKIP;
        end else begin
          mem_we = in_acc && (payload_seen < MaxPl);
          if (payload_seen != 8'hff) payload_seen_next = payload_seen + 8'd1;
        end
      end
      S_SKIP:  parse_state_next = S_SKIP;
      default: parse_state_next = S_TID0;
    endcase
  end

  // Chunk-end decision on the payload
  assign fin_decide = (parse_state_next == S_DATA) && (payload_seen_next != 8'd0);
  assign fin_ok     = fin_decide && (payload_seen_next == bytecount_reg);
  assign fin_status = fin_decide ? (fin_ok ? ST_OK : ST_LEN) : pend_status_next;

  assign rd_en   = ((ctl == C_SUM) && out_free && emit_pl) ||
                   ((ctl == C_DATA) && out_free && !rd_last);
  assign rd_addr = (ctl == C_SUM) ? '0 : rd_idx + AW'(1);

  // Payload RAM
  always_ff @(posedge clk) begin
    if (mem_we) mem[payload_seen[AW-1:0]] <= rx;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_fc    <= 8'd3;
      wmulti_fc  <= 8'd16;
      wsingle_fc <= 8'd6;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_READ_FC:    read_fc    <= cfg_wdata;
        CFG_WMULTI_FC:  wmulti_fc  <= cfg_wdata;
        CFG_WSINGLE_FC: wsingle_fc <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parser and header fields
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= S_TID0;
      pend_status   <= ST_NONE;
      payload_seen  <= 8'd0;
      func_kind     <= K_READ;
      tid_reg       <= '0;
      pid_reg       <= '0;
      len_reg       <= '0;
      uid_reg       <= '0;
      func_reg      <= '0;
      addr_reg      <= '0;
      count_reg     <= '0;
      bytecount_reg <= '0;
      emit_status   <= ST_NONE;
      emit_pl       <= 1'b0;
    end else if (in_acc) begin
      unique case (parse_state)
        S_TID0:  tid_reg <= {rx, 8'd0};
        S_TID1:  tid_reg <= {tid_reg[15:8], rx};
        S_PID0:  pid_reg <= {rx, 8'd0};
        S_PID1:  pid_reg <= {pid_reg[15:8], rx};
        S_LEN0:  len_reg <= {rx, 8'd0};
        S_LEN1:  len_reg <= {len_reg[15:8], rx};
        S_UID:   uid_reg <= rx;
        S_FUNC: begin
          func_reg <= rx;
          // classify once: read, then single write, then multiple write
          if (rx == read_fc)         func_kind <= K_READ;
          else if (rx == wsingle_fc) func_kind <= K_SINGLE;
          else if (rx == wmulti_fc)  func_kind <= K_MULTI;
        end
        S_ADDR0: addr_reg <= {rx, 8'd0};
        S_ADDR1: addr_reg <= {addr_reg[15:8], rx};
        S_NUM0:  if (func_kind != K_SINGLE) count_reg <= {rx, 8'd0};
        S_NUM1:  count_reg <= (func_kind == K_SINGLE) ? 16'd1 : {count_reg[15:8], rx};
        S_DLEN:  bytecount_reg <= rx;
        default: ;
      endcase
      if (s_tlast) begin
        // restart the parse for the next chunk
        parse_state  <= S_TID0;
        pend_status  <= ST_NONE;
        payload_seen <= 8'd0;
        emit_status  <= fin_status;
        emit_pl      <= fin_ok;
      end else begin
        parse_state  <= parse_state_next;
        pend_status  <= pend_status_next;
        payload_seen <= payload_seen_next;
      end
    end
  end

  // Output sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl      <= C_PARSE;
      m_tvalid <= 1'b0;
      rd_idx   <= '0;
    end else begin
      if ((ctl == C_SUM || ctl == C_DATA) && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (ctl)
        C_PARSE: if (in_acc && s_tlast) ctl <= C_SUM;
        C_SUM: begin
          if (out_free) begin
            rd_idx   <= '0;
            ctl      <= emit_pl ? C_DATA : C_PARSE;
          end
        end
        C_DATA: begin
          if (out_free) begin
            if (rd_last) ctl <= C_PARSE;
            else rd_idx <= rd_idx + AW'(1);
          end
        end
        default: ctl <= C_PARSE;
      endcase
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if ((ctl == C_SUM || ctl == C_DATA) && out_free) begin
      out_tid   <= tid_reg;
      out_pid   <= pid_reg;
      out_len   <= len_reg;
      out_uid   <= uid_reg;
      out_func  <= func_reg;
      out_addr  <= addr_reg;
      out_count <= count_reg;
      out_bc    <= bytecount_reg;
      if (ctl == C_SUM) begin
        out_status <= emit_status;
        out_pb     <= 8'd0;
        out_user   <= 1'b0;
        out_last   <= !emit_pl;
      end else begin
        out_status <= ST_OK;
        out_pb     <= mem_q;
        out_user   <= 1'b1;
        out_last   <= rd_last;
      end
    end
  end

  assign m_tdata = {{OutPadW{1'b0}}, out_pb, out_bc, out_count, out_addr, out_func,
                    out_uid, out_len, out_pid, out_tid, out_status};
  assign m_tuser = out_user;
  assign m_tlast = out_last;

  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> out_status == ST_OK)
    else $error("payload item without ok status");

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl == C_DATA |-> {{(8-AW){1'b0}}, rd_idx} < bytecount_reg)
    else $error("payload read beyond byte count");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tlast |=> ctl == C_SUM && parse_state == S_TID0 &&
                          pend_status == ST_NONE && payload_seen == 8'd0)
    else $error("parser not restarted at chunk end");

  a_no_write_on_emit: assert property (@(posedge clk) disable iff (rst)
    ctl != C_PARSE |-> !mem_we && !s_tready)
    else $error("payload written while replaying");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Streams Modbus TCP request chunks into the request parser byte by byte and
// checks every summary and payload item against a cycle-free model of the
// parser, across several function code settings and idling modes.
// ----------------------------------------------------------------------------
package mbap_check_pkg;
  import mtrp_pkg::*;

  localparam int PayloadDepth = 32;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] tid;
    logic [15:0] pid;
    logic [15:0] len;
    logic [7:0]  uid;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] count;
    logic [7:0]  bcount;
    logic [7:0]  pbyte;
    logic        isp;
    logic        last;
  } mbap_item_t;

  class parse_checker;
    logic [7:0]   fc_read, fc_multi, fc_single;
    parse_state_t st;
    func_kind_t   kind;
    logic [2:0]   status;
    logic [15:0]  tid, pid, len, addr, count;
    logic [7:0]   uid, func, bcount;
    int           seen;
    logic [7:0]   store [PayloadDepth];
    mbap_item_t   expected_items [$];
    int           errors, reported, items_checked, payload_checked;
    int           status_seen [5];

    function void clear();
      fc_read   = 8'd3;
      fc_multi  = 8'd16;
      fc_single = 8'd6;
      st        = S_TID0;
      kind      = K_READ;
      status    = ST_NONE;
      tid = '0; pid = '0; len = '0; addr = '0; count = '0;
      uid = '0; func = '0; bcount = '0;
      seen = 0;
      errors = 0; reported = 0; items_checked = 0; payload_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_code(logic [CfgAddrW-1:0] idx, logic [7:0] v);
      case (idx)
        CFG_READ_FC:    fc_read = v;
        CFG_WMULTI_FC:  fc_multi = v;
        CFG_WSINGLE_FC: fc_single = v;
        default: ;
      endcase
    endfunction

    function void push_item(logic [7:0] pb, logic isp, logic lst);
      mbap_item_t it;
      it.status = status;
      it.tid    = tid;
      it.pid    = pid;
      it.len    = len;
      it.uid    = uid;
      it.func   = func;
      it.addr   = addr;
      it.count  = count;
      it.bcount = bcount;
      it.pbyte  = pb;
      it.isp    = isp;
      it.last   = lst;
      expected_items.push_back(it);
    endfunction

    // Advance the parser by one accepted byte; a chunk end queues its items
    function void parse_byte(logic [7:0] b, logic fin);
      bit emit;
      int n;
      emit = 0;
      case (st)
        S_TID0:  begin tid = {b, 8'h00}; st = S_TID1; end
        S_TID1:  begin tid[7:0] = b; st = S_PID0; end
        S_PID0:  begin pid = {b, 8'h00}; st = S_PID1; end
        S_PID1: begin
          pid[7:0] = b;
          if (pid != 16'h0000) begin
            status = ST_PID;
            st = S_TID0;
          end else begin
            st = S_LEN0;
          end
        end
        S_LEN0:  begin len = {b, 8'h00}; st = S_LEN1; end
        S_LEN1:  begin len[7:0] = b; st = S_UID; end
        S_UID:   begin uid = b; st = S_FUNC; end
        S_FUNC: begin
          func = b;
          // read wins over single, single over multi
          if (b == fc_read) begin
            kind = K_READ; st = S_ADDR0;
          end else if (b == fc_single) begin
            kind = K_SINGLE; st = S_ADDR0;
          end else if (b == fc_multi) begin
            kind = K_MULTI; st = S_ADDR0;
          end else begin
            status = ST_FUNC; st = S_TID0;
          end
        end
        S_ADDR0: begin addr = {b, 8'h00}; st = S_ADDR1; end
        S_ADDR1: begin addr[7:0] = b; st = S_NUM0; end
        S_NUM0: begin
          if (kind != K_SINGLE) count = {b, 8'h00};
          st = S_NUM1;
        end
        S_NUM1: begin
          if (kind == K_SINGLE) begin
            count = 16'd1;
            status = ST_OK;
            st = S_TID0;
          end else begin
            count[7:0] = b;
            if (kind == K_READ) begin
              status = ST_OK;
              st = S_TID0;
            end else begin
              st = S_DLEN;
            end
          end
        end
        S_DLEN: begin
          bcount = b;
          seen = 0;
          st = (b == 8'd0) ? S_TID0 : S_DATA;
        end
        S_DATA: begin
          if (seen == 0 && bcount >= PayloadDepth) begin
            status = ST_LEN;
            st = S_SKIP;
          end else begin
            if (seen < PayloadDepth) store[seen] = b;
            if (seen < 255) seen++;
          end
        end
        S_SKIP: ;
        default: st = S_TID0;
      endcase

      if (!fin) return;

      if (st == S_DATA && seen > 0) begin
        if (seen == bcount) begin
          status = ST_OK;
          emit = 1;
        end else begin
          status = ST_LEN;
        end
      end
      n = emit ? 1 + bcount : 1;
      push_item(8'h00, 1'b0, n == 1);
      for (int k = 1; k < n; k++) push_item(store[k-1], 1'b1, k == n - 1);

      st = S_TID0;
      status = ST_NONE;
      seen = 0;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("mismatch on item %0d, %s: expected %0h, got %0h",
                   items_checked, name, want, got);
        end
      end
    endfunction

    function void check_item(logic [OutDataW-1:0] d, logic u, logic l);
      mbap_item_t e;
      if (expected_items.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("result item with nothing expected, tdata %h", d);
        end
        return;
      end
      e = expected_items.pop_front();
      items_checked++;
      if (e.isp) payload_checked++;
      else status_seen[e.status]++;
      compare_field("status",           e.status, d[2:0]);
      compare_field("transaction_id",   e.tid,    d[18:3]);
      compare_field("protocol_id",      e.pid,    d[34:19]);
      compare_field("frame_length",     e.len,    d[50:35]);
      compare_field("unit_id",          e.uid,    d[58:51]);
      compare_field("function_code",    e.func,   d[66:59]);
      compare_field("register_address", e.addr,   d[82:67]);
      compare_field("register_count",   e.count,  d[98:83]);
      compare_field("byte_count",       e.bcount, d[106:99]);
      compare_field("payload_byte",     e.pbyte,  d[114:107]);
      compare_field("padding",          16'h0000, d[119:115]);
      compare_field("is_payload",       e.isp,    u);
      compare_field("last",             e.last,   l);
    endfunction
  endclass
endpackage

module tb_top;
  import mtrp_pkg::*;
  import mbap_check_pkg::*;

  localparam int BytesPerPhase = 84;
  localparam int TailCycles    = 12;
  localparam int HoldCycles    = 150;
  localparam int LimitCycles   = 200000;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [7:0]          cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  parse_checker sb = new;
  logic [7:0]   chunk_q [$];
  int           send_idle_pct, recv_stall_pct;
  int           hold_reqs, holds_done, hold_left;
  int           bytes_sent, chunks_sent, cycle_count;

  modbus_tcp_request_parser #(.MAX_PAYLOAD(PayloadDepth)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("run stopped after %0d cycles with %0d items outstanding",
               cycle_count, sb.expected_items.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Check outputs before noting inputs taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_item(m_tdata, m_tuser, m_tlast);
      if (s_tvalid && s_tready) sb.parse_byte(s_tdata, s_tlast);
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (holds_done < hold_reqs) begin
      holds_done++;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [15:0] pick16();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick8();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic void push16(logic [15:0] v);
    chunk_q.push_back(v[15:8]);
    chunk_q.push_back(v[7:0]);
  endfunction

  function automatic void push_header(logic [15:0] pid, logic [7:0] fc);
    push16(pick16());
    push16(pid);
    push16(pick16());
    chunk_q.push_back(pick8());
    chunk_q.push_back(fc);
  endfunction

  function automatic logic [7:0] odd_code();
    logic [7:0] c;
    c = 8'($urandom);
    while (c == sb.fc_read || c == sb.fc_multi || c == sb.fc_single) c = c + 8'd1;
    return c;
  endfunction

  // Append one request; returns 1 when nothing more may follow in the chunk
  function automatic bit add_frame();
    int         sel, v, bc, np;
    logic [15:0] pid;
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      push_header(16'h0000, sb.fc_read);
      push16(pick16());
      push16(pick16());
      return 0;
    end
    if (sel < 36) begin
      push_header(16'h0000, sb.fc_single);
      push16(pick16());
      push16(pick16());
      return 0;
    end
    if (sel < 66) begin
      push_header(16'h0000, sb.fc_multi);
      push16(pick16());
      push16(pick16());
      v = $urandom_range(0, 99);
      if (v < 55) begin
        bc = $urandom_range(1, 8);
        np = bc;
      end else if (v < 65) begin
        bc = PayloadDepth - 1;
        np = bc;
      end else if (v < 72) begin
        bc = $urandom_range(0, 1) ? PayloadDepth : $urandom_range(PayloadDepth, 255);
        np = $urandom_range(1, 4);
      end else if (v < 82) begin
        bc = $urandom_range(2, 8);
        np = $urandom_range(0, 1) ? bc - 1 : bc + 1;
      end else if (v < 90) begin
        bc = $urandom_range(1, 8);
        np = 0;
      end else begin
        chunk_q.push_back(8'h00);
        return 0;
      end
      chunk_q.push_back(8'(bc));
      repeat (np) chunk_q.push_back(8'($urandom));
      return 1;
    end
    if (sel < 76) begin
      push16(pick16());
      pid = pick16();
      if (pid == 16'h0000) pid = 16'h0001;
      push16(pid);
      return 0;
    end
    if (sel < 86) begin
      push_header(16'h0000, odd_code());
      return 0;
    end
    repeat ($urandom_range(1, 6)) chunk_q.push_back(8'($urandom));
    return 1;
  endfunction

  function automatic void build_chunk();
    int frames;
    chunk_q.delete();
    frames = $urandom_range(1, 3);
    for (int i = 0; i < frames; i++) begin
      if (add_frame()) break;
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_chunk();
    foreach (chunk_q[i]) send_byte(chunk_q[i], i == chunk_q.size() - 1);
    chunks_sent++;
  endtask

  // Drop valid and hold until every queued item has been seen
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.expected_items.size() != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
  endtask

  task automatic write_code(logic [CfgAddrW-1:0] idx, logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_code(idx, v);
    @(negedge clk);
  endtask

  task automatic set_codes(logic [7:0] rd, logic [7:0] wm, logic [7:0] ws);
    write_code(CFG_READ_FC, rd);
    write_code(CFG_WMULTI_FC, wm);
    write_code(CFG_WSINGLE_FC, ws);
  endtask

  initial begin : stimulus
    int  phase_start;
    bit  paused;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_reqs = 0;
    holds_done = 0;
    hold_left = 0;
    bytes_sent = 0;
    chunks_sent = 0;
    cycle_count = 0;
    sb.clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Protocol id error followed by an all-ones read: last status wins
    chunk_q.delete();
    push16(16'hFFFF);
    push16(16'hFFFF);
    push16(16'hFFFF);
    push16(16'h0000);
    push16(16'hFFFF);
    chunk_q.push_back(8'hFF);
    chunk_q.push_back(sb.fc_read);
    push16(16'hFFFF);
    push16(16'hFFFF);
    send_chunk();
    // Single write with zero fields: count forced to one
    chunk_q.delete();
    push16(16'h0000);
    push16(16'h0000);
    push16(16'h0000);
    chunk_q.push_back(8'h00);
    chunk_q.push_back(sb.fc_single);
    push16(16'h0000);
    push16(16'h0000);
    send_chunk();
    // One-byte chunk: no frame
    chunk_q.delete();
    chunk_q.push_back(8'hA5);
    send_chunk();
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: set_codes(8'd0, 8'd255, 8'd0);
        2: set_codes(8'd255, 8'd0, 8'd0);
        3: set_codes(8'h42, 8'h42, 8'd255);
        4: set_codes(8'd3, 8'd16, 8'd6);
        default: ;
      endcase
      case (p)
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        3: begin send_idle_pct = 15; recv_stall_pct = 15; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // Fill the parser against a stalled receiver
      if (p == 4) hold_reqs++;
      phase_start = bytes_sent;
      paused = 0;
      while (bytes_sent - phase_start < BytesPerPhase) begin
        build_chunk();
        send_chunk();
        if (p == 1 && !paused && bytes_sent - phase_start > BytesPerPhase / 2) begin
          wait_drained();
          paused = 1;
        end
      end
      wait_drained();
    end

    $display("Sent %0d bytes in %0d chunks over five function code settings and idling modes",
             bytes_sent, chunks_sent);
    $display("Checked %0d items (%0d payload); ok %0d, pid err %0d, func err %0d, len err %0d, none %0d; %0d mismatches",
             sb.items_checked, sb.payload_checked, sb.status_seen[ST_OK],
             sb.status_seen[ST_PID], sb.status_seen[ST_FUNC], sb.status_seen[ST_LEN],
             sb.status_seen[ST_NONE], sb.errors);
    if (sb.errors == 0 && sb.expected_items.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* sim.f */
src/mtrp_pkg.sv
src/modbus_tcp_request_parser.sv
verif/tb_top.sv
